/* hdl/dqp_pkg.sv */
// Shared types, codes and result builders for the DNS query parser.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package dqp_pkg;

  localparam int DQP_NAME_LIMIT = 255;
  localparam int DQP_QDEPTH     = 4;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_TAIL,
    PH_DROP
  } dqp_phase_t;

  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_CHAR     = 3'd1;
  localparam logic [2:0] KIND_QDONE    = 3'd2;
  localparam logic [2:0] KIND_ERROR    = 3'd3;
  localparam logic [2:0] KIND_MSG_DONE = 3'd4;

  localparam logic [15:0] ERR_RECORDS  = 16'd0;
  localparam logic [15:0] ERR_TOO_LONG = 16'd1;
  localparam logic [15:0] ERR_TRUNC    = 16'd2;

  localparam logic [3:0]  HDR_LAST_IDX = 4'd11;
  localparam logic [7:0]  LABEL_MAX    = 8'd63;
  localparam logic [15:0] DOT_CHAR     = 16'h002E;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] msg_id;
    logic        qr_bit;
    logic [3:0]  opcode;
    logic        aa_bit;
    logic        tc_bit;
    logic        rd_bit;
    logic        ra_bit;
    logic [3:0]  rcode;
    logic [15:0] question_count;
    logic [15:0] value;
    logic [15:0] query_class;
  } dqp_result_t;

  // up to two results produced by one accepted byte
  typedef struct packed {
    logic [1:0]  cnt;
    dqp_result_t first;
    dqp_result_t second;
  } dqp_push_t;

  function automatic dqp_result_t mk_plain(logic [2:0] kind, logic [15:0] value,
                                           logic [15:0] cls);
    dqp_result_t r;
    r             = '0;
    r.kind        = kind;
    r.value       = value;
    r.query_class = cls;
    return r;
  endfunction

  // s holds header bytes 0..5: id, flags, qdcount
  function automatic dqp_result_t mk_header(logic [47:0] s);
    dqp_result_t r;
    r                = '0;
    r.kind           = KIND_HEADER;
    r.msg_id         = s[47:32];
    r.qr_bit         = s[31];
    r.opcode         = s[30:27];
    r.aa_bit         = s[26];
    r.tc_bit         = s[25];
    r.rd_bit         = s[24];
    r.ra_bit         = s[23];
    r.rcode          = s[19:16];
    r.question_count = s[15:0];
    return r;
  endfunction

endpackage

/* hdl/dqp_if.sv */
// Valid/ready channel interfaces: packet bytes in, parse results out.
// No dependencies.
`timescale 1ns / 1ps

interface dqp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_end;

  modport source (output valid, output data_byte, output packet_end, input ready);
  modport sink   (input valid, input data_byte, input packet_end, output ready);
endinterface

interface dqp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] msg_id;
  logic        qr_bit;
  logic [3:0]  opcode;
  logic        aa_bit;
  logic        tc_bit;
  logic        rd_bit;
  logic        ra_bit;
  logic [3:0]  rcode;
  logic [15:0] question_count;
  logic [15:0] value;
  logic [15:0] query_class;

  modport source (output valid, output kind, output msg_id, output qr_bit, output opcode,
                  output aa_bit, output tc_bit, output rd_bit, output ra_bit,
                  output rcode, output question_count, output value,
                  output query_class, input ready);
  modport sink   (input valid, input kind, input msg_id, input qr_bit, input opcode,
                  input aa_bit, input tc_bit, input rd_bit, input ra_bit,
                  input rcode, input question_count, input value,
                  input query_class, output ready);
endinterface

/* hdl/dqp_core.sv */
// Parser state machine: consumes one packet byte per accepted word and
// produces zero to two results for it. Depends on dqp_pkg.
`timescale 1ns / 1ps

module dqp_core #(
  parameter int NAME_LIMIT = dqp_pkg::DQP_NAME_LIMIT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              packet_end,
  output dqp_pkg::dqp_push_t push
);
  import dqp_pkg::*;

  localparam logic [7:0] LAST_POS = 8'(NAME_LIMIT - 1);

  dqp_phase_t  phase_r, phase_nxt, ph_mid;
  logic [3:0]  hdr_idx_r, hdr_idx_nxt;
  logic [47:0] hdr_store_r, hdr_store_nxt;
  logic        rec_r, rec_nxt;
  logic [15:0] q_left_r, q_left_nxt;
  logic [7:0]  name_pos_r, name_pos_nxt;
  logic [1:0]  tail_idx_r, tail_idx_nxt;
  logic [23:0] tc_r, tc_nxt;

  dqp_result_t res_a, res_b;
  logic [1:0]  n;

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    hdr_idx_nxt   = hdr_idx_r;
    hdr_store_nxt = hdr_store_r;
    rec_nxt       = rec_r;
    q_left_nxt    = q_left_r;
    name_pos_nxt  = name_pos_r;
    tail_idx_nxt  = tail_idx_r;
    tc_nxt        = tc_r;
    ph_mid        = phase_r;
    if (fire) begin
      case (phase_r)
        PH_HEADER: begin
          if (hdr_idx_r < 4'd6) begin
            hdr_store_nxt = {hdr_store_r[39:0], data_byte};
          end
          rec_nxt = ((hdr_idx_r == 4'd0) ? 1'b0 : rec_r) |
                    ((hdr_idx_r inside {[4'd6:4'd9]}) && (data_byte != 8'd0));
          hdr_idx_nxt = hdr_idx_r + 4'd1;
          if (hdr_idx_r == HDR_LAST_IDX) begin
            hdr_idx_nxt = 4'd0;
            if (rec_r) begin
              phase_nxt = PH_DROP;
            end else begin
              q_left_nxt = hdr_store_r[15:0];
              if (hdr_store_r[15:0] == 16'd0) begin
                phase_nxt = PH_DROP;
              end else begin
                phase_nxt    = PH_NAME;
                name_pos_nxt = 8'd0;
              end
            end
          end
        end
        PH_NAME: begin
          if (name_pos_r == 8'd0) begin
            name_pos_nxt = 8'd1;
          end else if (data_byte == 8'd0) begin
            phase_nxt    = PH_TAIL;
            tail_idx_nxt = 2'd0;
          end else if (name_pos_r >= LAST_POS) begin
            phase_nxt = PH_DROP;
          end else begin
            name_pos_nxt = name_pos_r + 8'd1;
          end
        end
        PH_TAIL: begin
          tc_nxt = {tc_r[15:0], data_byte};
          if (tail_idx_r == 2'd3) begin
            tail_idx_nxt = 2'd0;
            q_left_nxt   = q_left_r - 16'd1;
            if (q_left_r == 16'd1) begin
              phase_nxt = PH_DROP;
            end else begin
              phase_nxt    = PH_NAME;
              name_pos_nxt = 8'd0;
            end
          end else begin
            tail_idx_nxt = tail_idx_r + 2'd1;
          end
        end
        default: begin
        end
      endcase
      ph_mid = phase_nxt;
      if (packet_end) begin
        phase_nxt    = PH_HEADER;
        hdr_idx_nxt  = 4'd0;
        name_pos_nxt = 8'd0;
        tail_idx_nxt = 2'd0;
      end
    end
  end

  // results for the accepted byte
  always_comb begin
    res_a = '0;
    res_b = '0;
    n     = 2'd0;
    if (fire) begin
      case (phase_r)
        PH_HEADER: begin
          if (hdr_idx_r == HDR_LAST_IDX) begin
            res_a = mk_header(hdr_store_r);
            n     = 2'd1;
            if (rec_r) begin
              res_b = mk_plain(KIND_ERROR, ERR_RECORDS, 16'd0);
              n     = 2'd2;
            end else if (hdr_store_r[15:0] == 16'd0) begin
              res_b = mk_plain(KIND_MSG_DONE, 16'd0, 16'd0);
              n     = 2'd2;
            end
          end
        end
        PH_NAME: begin
          if (name_pos_r != 8'd0 && data_byte != 8'd0) begin
            res_a = mk_plain(KIND_CHAR,
                             (data_byte <= LABEL_MAX) ? DOT_CHAR : {8'd0, data_byte},
                             16'd0);
            n     = 2'd1;
            if (name_pos_r >= LAST_POS) begin
              res_b = mk_plain(KIND_ERROR, ERR_TOO_LONG, 16'd0);
              n     = 2'd2;
            end
          end
        end
        PH_TAIL: begin
          if (tail_idx_r == 2'd3) begin
            res_a = mk_plain(KIND_QDONE, tc_r[23:8], {tc_r[7:0], data_byte});
            n     = 2'd1;
            if (q_left_r == 16'd1) begin
              res_b = mk_plain(KIND_MSG_DONE, 16'd0, 16'd0);
              n     = 2'd2;
            end
          end
        end
        default: begin
        end
      endcase
      if (packet_end && ph_mid != PH_DROP) begin
        if (n == 2'd0) begin
          res_a = mk_plain(KIND_ERROR, ERR_TRUNC, 16'd0);
          n     = 2'd1;
        end else begin
          res_b = mk_plain(KIND_ERROR, ERR_TRUNC, 16'd0);
          n     = 2'd2;
        end
      end
    end
  end

  assign push = '{cnt: n, first: res_a, second: res_b};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hdr_idx_r  <= 4'd0;
      rec_r      <= 1'b0;
      q_left_r   <= 16'd0;
      name_pos_r <= 8'd0;
      tail_idx_r <= 2'd0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_idx_r  <= hdr_idx_nxt;
      rec_r      <= rec_nxt;
      q_left_r   <= q_left_nxt;
      name_pos_r <= name_pos_nxt;
      tail_idx_r <= tail_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_store_r <= hdr_store_nxt;
    tc_r        <= tc_nxt;
  end

`ifndef ASSERT_OFF
  a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    fire && packet_end |=> phase_r == PH_HEADER && hdr_idx_r == 4'd0)
    else $error("packet end did not return parser to header phase");

  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && phase_r == PH_DROP && !packet_end |-> push.cnt == 2'd0)
    else $error("result produced while dropping bytes");

  a_hdr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_idx_r <= HDR_LAST_IDX)
    else $error("header byte index out of range");
`endif

endmodule

/* hdl/dqp_out_queue.sv */
// Shifting result queue: takes up to two results per cycle, presents the
// oldest at a fixed head slot. Depends on dqp_pkg.
`timescale 1ns / 1ps

module dqp_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dqp_pkg::dqp_push_t   push,
  input  logic                 pop,
  output dqp_pkg::dqp_result_t head,
  output logic                 head_valid,
  output logic                 room
);
  import dqp_pkg::*;

  localparam int CW = $clog2(DQP_QDEPTH + 1);
  localparam int IW = $clog2(DQP_QDEPTH);

  dqp_result_t q_r   [DQP_QDEPTH];
  dqp_result_t q_nxt [DQP_QDEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt, cnt_mid;
  logic [IW-1:0] wr_idx;

  always_comb begin
    q_nxt   = q_r;
    cnt_mid = cnt_r;
    if (pop && cnt_r != '0) begin
      for (int i = 0; i < DQP_QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      cnt_mid = cnt_r - CW'(1);
    end
    wr_idx = cnt_mid[IW-1:0];
    if (push.cnt != 2'd0) begin
      q_nxt[wr_idx] = push.first;
    end
    if (push.cnt == 2'd2) begin
      q_nxt[wr_idx + IW'(1)] = push.second;
    end
    cnt_nxt = cnt_mid + CW'(push.cnt);
  end

  assign head       = q_r[0];
  assign head_valid = (cnt_r != '0);
  assign room       = (cnt_r <= CW'(DQP_QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> cnt_r <= CW'(DQP_QDEPTH - 2))
    else $error("result queue written without room");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_valid && push.cnt == 2'd0 |=> cnt_r == CW'($past(cnt_r) - CW'(1)))
    else $error("result queue count wrong after pop");
`endif

endmodule

/* hdl/dns_query_parser.sv */
// Top level of the DNS query parser: byte channel in, result channel out.
// Depends on dqp_pkg, dqp_if, dqp_core and dqp_out_queue.
//
// Accepts one packet byte per cycle (packet_end on the last) and emits zero
// to two result words per byte: header, name characters, question done,
// message done and error codes. Results pass through a registered 4-entry
// result queue, one result word per cycle while out_chan.ready is high;
// the input takes a byte whenever the queue has two free entries, so the
// input rate is one byte per cycle while the output keeps up and only
// bytes with two results can stall it. No clearing after reset.
`timescale 1ns / 1ps

module dns_query_parser #(
  parameter int NAME_LIMIT = dqp_pkg::DQP_NAME_LIMIT
) (
  input  logic       clk,
  input  logic       rst_n,
  dqp_in_if.sink     in_chan,
  dqp_out_if.source  out_chan
);
  import dqp_pkg::*;

  dqp_push_t   push;
  dqp_result_t head;
  logic        head_valid;
  logic        room;
  logic        fire;

  assign in_chan.ready = room;
  assign fire          = in_chan.valid & room;

  dqp_core #(
    .NAME_LIMIT (NAME_LIMIT)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .data_byte  (in_chan.data_byte),
    .packet_end (in_chan.packet_end),
    .push       (push)
  );

  dqp_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_chan.ready),
    .head       (head),
    .head_valid (head_valid),
    .room       (room)
  );

  assign out_chan.valid          = head_valid;
  assign out_chan.kind           = head.kind;
  assign out_chan.msg_id         = head.msg_id;
  assign out_chan.qr_bit         = head.qr_bit;
  assign out_chan.opcode         = head.opcode;
  assign out_chan.aa_bit         = head.aa_bit;
  assign out_chan.tc_bit         = head.tc_bit;
  assign out_chan.rd_bit         = head.rd_bit;
  assign out_chan.ra_bit         = head.ra_bit;
  assign out_chan.rcode          = head.rcode;
  assign out_chan.question_count = head.question_count;
  assign out_chan.value          = head.value;
  assign out_chan.query_class    = head.query_class;

endmodule

/* dv/dqp_result_checker.sv */
// Result checker for dns_query_parser: tracks the parse state from accepted
// input words, predicts the result words and compares them in order.
// Depends on dqp_pkg and dqp_if.
`timescale 1ns / 1ps

module dqp_result_checker #(
  parameter int NAME_LIM = dqp_pkg::DQP_NAME_LIMIT
) (
  input  logic clk,
  input  logic rst_n,
  dqp_in_if    in_mon,
  dqp_out_if   out_mon,
  output int   fail_count,
  output int   words_pending
);
  import dqp_pkg::*;

  dqp_phase_t  phase;
  logic [3:0]  hdr_idx;
  logic [47:0] hdr_bytes;
  logic        records_seen;
  logic [15:0] questions_left;
  logic [7:0]  name_pos;
  logic [1:0]  tail_idx;
  logic [31:0] type_class;
  dqp_result_t expected_words[$];

  function automatic dqp_result_t status_word(logic [2:0] k, logic [15:0] v,
                                              logic [15:0] c);
    dqp_result_t w;
    w             = '0;
    w.kind        = k;
    w.value       = v;
    w.query_class = c;
    return w;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [15:0] fl;
    dqp_result_t w;
    case (phase)
      PH_HEADER: begin
        if (hdr_idx == 4'd0) begin
          hdr_bytes    = '0;
          records_seen = 1'b0;
        end
        if (hdr_idx < 4'd6) hdr_bytes = {hdr_bytes[39:0], b};
        else if (hdr_idx < 4'd10 && b != 8'd0) records_seen = 1'b1;
        if (hdr_idx == HDR_LAST_IDX) begin
          hdr_idx          = 4'd0;
          fl               = hdr_bytes[31:16];
          w                = '0;
          w.kind           = KIND_HEADER;
          w.msg_id         = hdr_bytes[47:32];
          w.qr_bit         = fl[15];
          w.opcode         = fl[14:11];
          w.aa_bit         = fl[10];
          w.tc_bit         = fl[9];
          w.rd_bit         = fl[8];
          w.ra_bit         = fl[7];
          w.rcode          = fl[3:0];
          w.question_count = hdr_bytes[15:0];
          expected_words.push_back(w);
          if (records_seen) begin
            expected_words.push_back(status_word(KIND_ERROR, ERR_RECORDS, '0));
            phase = PH_DROP;
          end else begin
            questions_left = hdr_bytes[15:0];
            if (questions_left == 16'd0) begin
              expected_words.push_back(status_word(KIND_MSG_DONE, '0, '0));
              phase = PH_DROP;
            end else begin
              phase    = PH_NAME;
              name_pos = 8'd0;
            end
          end
        end else begin
          hdr_idx = hdr_idx + 4'd1;
        end
      end
      PH_NAME: begin
        // leading length byte is skipped whatever its value
        if (name_pos == 8'd0) begin
          name_pos = 8'd1;
        end else if (b == 8'd0) begin
          phase      = PH_TAIL;
          tail_idx   = 2'd0;
          type_class = '0;
        end else begin
          expected_words.push_back(status_word(KIND_CHAR,
                                               (b <= LABEL_MAX) ? DOT_CHAR : {8'd0, b}, '0));
          if (name_pos >= NAME_LIM - 1) begin
            expected_words.push_back(status_word(KIND_ERROR, ERR_TOO_LONG, '0));
            phase = PH_DROP;
          end else begin
            name_pos = name_pos + 8'd1;
          end
        end
      end
      PH_TAIL: begin
        type_class = {type_class[23:0], b};
        if (tail_idx == 2'd3) begin
          tail_idx = 2'd0;
          expected_words.push_back(status_word(KIND_QDONE, type_class[31:16],
                                               type_class[15:0]));
          questions_left = questions_left - 16'd1;
          if (questions_left == 16'd0) begin
            expected_words.push_back(status_word(KIND_MSG_DONE, '0, '0));
            phase = PH_DROP;
          end else begin
            phase    = PH_NAME;
            name_pos = 8'd0;
          end
        end else begin
          tail_idx = tail_idx + 2'd1;
        end
      end
      default: ;
    endcase
    if (last) begin
      if (phase != PH_DROP)
        expected_words.push_back(status_word(KIND_ERROR, ERR_TRUNC, '0));
      phase    = PH_HEADER;
      hdr_idx  = 4'd0;
      name_pos = 8'd0;
      tail_idx = 2'd0;
    end
  endtask

  task automatic check_word(input dqp_result_t got);
    dqp_result_t want;
    if (expected_words.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected word: kind %0d value %h class %h", got.kind, got.value,
                 got.query_class);
      return;
    end
    want = expected_words.pop_front();
    if (got.kind !== want.kind || got.msg_id !== want.msg_id ||
        got.qr_bit !== want.qr_bit || got.opcode !== want.opcode ||
        got.aa_bit !== want.aa_bit || got.tc_bit !== want.tc_bit ||
        got.rd_bit !== want.rd_bit || got.ra_bit !== want.ra_bit ||
        got.rcode !== want.rcode || got.question_count !== want.question_count ||
        got.value !== want.value || got.query_class !== want.query_class) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch exp: kind %0d id %h flags %b rcode %h qd %h value %h class %h",
                 want.kind, want.msg_id,
                 {want.qr_bit, want.opcode, want.aa_bit, want.tc_bit, want.rd_bit,
                  want.ra_bit}, want.rcode, want.question_count, want.value,
                 want.query_class);
        $display("         got: kind %0d id %h flags %b rcode %h qd %h value %h class %h",
                 got.kind, got.msg_id,
                 {got.qr_bit, got.opcode, got.aa_bit, got.tc_bit, got.rd_bit,
                  got.ra_bit}, got.rcode, got.question_count, got.value,
                 got.query_class);
      end
    end
  endtask

  always @(posedge clk) begin
    dqp_result_t got;
    if (!rst_n) begin
      phase          = PH_HEADER;
      hdr_idx        = 4'd0;
      hdr_bytes      = '0;
      records_seen   = 1'b0;
      questions_left = '0;
      name_pos       = 8'd0;
      tail_idx       = 2'd0;
      type_class     = '0;
      expected_words.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        parse_byte(in_mon.data_byte, in_mon.packet_end);
      if (out_mon.valid && out_mon.ready) begin
        got.kind           = out_mon.kind;
        got.msg_id         = out_mon.msg_id;
        got.qr_bit         = out_mon.qr_bit;
        got.opcode         = out_mon.opcode;
        got.aa_bit         = out_mon.aa_bit;
        got.tc_bit         = out_mon.tc_bit;
        got.rd_bit         = out_mon.rd_bit;
        got.ra_bit         = out_mon.ra_bit;
        got.rcode          = out_mon.rcode;
        got.question_count = out_mon.question_count;
        got.value          = out_mon.value;
        got.query_class    = out_mon.query_class;
        check_word(got);
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

/* dv/tb.sv */
// Testbench top for dns_query_parser: builds directed and random query
// packets, drives them with random stalls and gives the verdict.
// Depends on dqp_pkg, dqp_if, dns_query_parser and dqp_result_checker.
`timescale 1ns / 1ps

module tb;
  import dqp_pkg::*;

  localparam int NAME_LIM = DQP_NAME_LIMIT;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   words_pending;
  int   in_idle_pct  = 36;
  int   out_idle_pct = 36;
  int   bytes_sent   = 0;
  logic [7:0] pkt[$];

  dqp_in_if  in_chan();
  dqp_out_if out_chan();

  dns_query_parser #(.NAME_LIMIT(NAME_LIM)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  dqp_result_checker #(.NAME_LIM(NAME_LIM)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  task automatic drive_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.data_byte  <= b;
    in_chan.packet_end <= last;
    do @(posedge clk); while (!in_chan.ready);
    bytes_sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++)
      drive_byte(pkt[i], i == pkt.size() - 1);
    pkt.delete();
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  task automatic add_word(input logic [15:0] w);
    pkt.push_back(w[15:8]);
    pkt.push_back(w[7:0]);
  endtask

  task automatic add_header(input logic [15:0] id, input logic [15:0] flags,
                            input logic [15:0] qd, input logic [15:0] an,
                            input logic [15:0] ns, input logic [15:0] ar);
    add_word(id);
    add_word(flags);
    add_word(qd);
    add_word(an);
    add_word(ns);
    add_word(ar);
  endtask

  // lead byte, body_len nonzero bytes, terminating zero
  task automatic add_name(input int body_len, input logic [7:0] lead);
    pkt.push_back(lead);
    repeat (body_len) pkt.push_back(8'($urandom_range(1, 255)));
    pkt.push_back(8'd0);
  endtask

  task automatic add_question(input int body_len);
    add_name(body_len, 8'($urandom_range(0, 255)));
    add_word(16'($urandom));
    add_word(16'($urandom));
  endtask

  task automatic random_packet();
    int sel;
    int nq;
    int cut;
    logic [15:0] an;
    logic [15:0] ns;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
    end else begin
      nq = (sel < 15) ? 0 : $urandom_range(1, 3);
      an = '0;
      ns = '0;
      if (sel >= 15 && sel < 23) begin
        if ($urandom_range(0, 1)) an = 16'($urandom_range(1, 65535));
        else ns = 16'($urandom_range(1, 65535));
      end
      add_header(16'($urandom), 16'($urandom),
                 16'(($urandom_range(0, 19) == 0) ? nq + 1 : nq), an, ns,
                 ($urandom_range(0, 9) < 3) ? 16'($urandom) : 16'd0);
      for (int q = 0; q < nq; q++)
        add_question(($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                  : $urandom_range(0, 12));
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, pkt.size());
        pkt = pkt[0:cut-1];
      end
    end
    send_packet();
  endtask

  initial begin
    int n_pkt;
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.data_byte  = 8'd0;
    in_chan.packet_end = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-ones id, flags and additional count, minimal name, additional bytes dropped
    add_header(16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'hFFFF);
    pkt.push_back(8'hFF);
    pkt.push_back(8'h00);
    add_word(16'hFFFF);
    add_word(16'hFFFF);
    repeat (3) pkt.push_back(8'($urandom));
    send_packet();
    // no questions: header then message done on the last header byte
    add_header(16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd0);
    send_packet();
    // answer records present
    add_header(16'h1234, 16'h0100, 16'd1, 16'd1, 16'd0, 16'd0);
    add_question(3);
    send_packet();
    // authority records present, ending on the header
    add_header(16'hBEEF, 16'h0080, 16'd1, 16'd0, 16'h0080, 16'd0);
    send_packet();
    // packet ends inside the header
    pkt.push_back(8'h00);
    send_packet();
    repeat (5) pkt.push_back(8'($urandom));
    send_packet();
    // ends right after the header with a question announced
    add_header(16'h8001, 16'h7800, 16'd1, 16'd0, 16'd0, 16'd0);
    send_packet();
    // zero lead byte, label-length boundary characters, then cut in the name
    add_header(16'h0042, 16'h000F, 16'd2, 16'd0, 16'd0, 16'd0);
    pkt.push_back(8'h00);
    pkt.push_back(8'd63);
    pkt.push_back(8'd64);
    pkt.push_back(8'd1);
    pkt.push_back(8'd255);
    pkt.push_back(8'h41);
    pkt.push_back(8'h00);
    add_word(16'h0001);
    add_word(16'h0001);
    pkt.push_back(8'd3);
    pkt.push_back(8'h61);
    send_packet();
    // ends on the last type/class byte while a question remains
    add_header(16'h5A5A, 16'h5A5A, 16'd2, 16'd0, 16'd0, 16'd0);
    add_question(4);
    send_packet();
    // ends inside type/class
    add_header(16'hA5A5, 16'hA5A5, 16'd1, 16'd0, 16'd0, 16'd0);
    add_question(2);
    pkt = pkt[0:pkt.size()-3];
    send_packet();
    // longest legal name
    add_header(16'h0001, 16'h0100, 16'd1, 16'd0, 16'd0, 16'd0);
    add_question(NAME_LIM - 2);
    send_packet();
    // name too long on the last byte of the packet
    add_header(16'h0002, 16'h0100, 16'd1, 16'd0, 16'd0, 16'd0);
    pkt.push_back(8'd7);
    repeat (NAME_LIM - 1) pkt.push_back(8'($urandom_range(1, 255)));
    send_packet();
    // name too long, rest of the packet dropped
    add_header(16'h0003, 16'h0100, 16'd1, 16'd0, 16'd0, 16'd0);
    add_question(NAME_LIM + 40);
    send_packet();
    // several well-formed questions
    add_header(16'h7777, 16'h0180, 16'd3, 16'd0, 16'd0, 16'd0);
    repeat (3) add_question($urandom_range(1, 10));
    send_packet();

    drain_results();

    n_pkt = 0;
    while (bytes_sent < 1600 || n_pkt < 12) begin
      if (n_pkt == 3) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else if (n_pkt == 8) begin
        in_idle_pct  = 36;
        out_idle_pct = 36;
      end
      if (n_pkt == 10) drain_results();
      random_packet();
      n_pkt++;
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
